/* rtl/core/power_status_monitor_macros.svh */
// Assertion helpers for the power status monitor.
`ifndef POWER_STATUS_MONITOR_MACROS_SVH
`define POWER_STATUS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/psm_pkg.sv */
package psm_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TimeW-1:0] TurnOnTimeoutRst  = TimeW'(10000);
  localparam logic [TimeW-1:0] TurnOffTimeoutRst = TimeW'(10000);

  // Config register indexes.
  localparam logic [CfgIdxW-1:0] CfgTurnOnTimeout  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTurnOffTimeout = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StStart   = 3'd0,
    StOn      = 3'd1,
    StOff     = 3'd2,
    StTurnOn  = 3'd3,
    StTurnOff = 3'd4,
    StOnErr   = 3'd5,
    StOffErr  = 3'd6
  } status_e;

  // Result of one evaluation step.
  typedef struct packed {
    status_e status;
    logic    load_start;
  } step_t;

endpackage

/* rtl/core/psm_in_if.sv */
interface psm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        led_lit;
  logic                        want_on;
  logic [psm_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, output led_lit, output want_on, output now_ms, input ready);
  modport sink   (input valid, input led_lit, input want_on, input now_ms, output ready);
endinterface

/* rtl/core/psm_out_if.sv */
interface psm_out_if;
  logic                        valid;
  logic                        ready;
  logic [psm_pkg::StatusW-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

/* rtl/core/psm_next.sv */
module psm_next (
  input  psm_pkg::status_e          state_i,
  input  logic                      led_lit_i,
  input  logic                      want_on_i,
  input  logic [psm_pkg::TimeW-1:0] now_ms_i,
  input  logic [psm_pkg::TimeW-1:0] start_ms_i,
  input  logic [psm_pkg::TimeW-1:0] on_timeout_i,
  input  logic [psm_pkg::TimeW-1:0] off_timeout_i,
  output psm_pkg::step_t            step_o
);

  logic [psm_pkg::TimeW-1:0] elapsed;

  // elapsed wraps mod 2^32
  assign elapsed = now_ms_i - start_ms_i;

  always_comb begin
    step_o.status     = state_i;
    step_o.load_start = 1'b0;
    case (state_i)
      psm_pkg::StTurnOn: begin
        if (elapsed >= on_timeout_i) step_o.status = psm_pkg::StOnErr;
        if (led_lit_i) step_o.status = psm_pkg::StOn;  // LED wins over timeout
      end
      psm_pkg::StTurnOff: begin
        if (elapsed >= off_timeout_i) step_o.status = psm_pkg::StOffErr;
        if (!led_lit_i) step_o.status = psm_pkg::StOff;
      end
      psm_pkg::StOnErr, psm_pkg::StOffErr: begin
        if (led_lit_i && want_on_i) begin
          step_o.status = psm_pkg::StOn;
        end else if (!led_lit_i && !want_on_i) begin
          step_o.status = psm_pkg::StOff;
        end
      end
      default: begin
        // start, on, off; also the unused code
        if (led_lit_i == want_on_i) begin
          step_o.status = want_on_i ? psm_pkg::StOn : psm_pkg::StOff;
        end else begin
          step_o.load_start = 1'b1;
          step_o.status     = want_on_i ? psm_pkg::StTurnOn : psm_pkg::StTurnOff;
        end
      end
    endcase
  end

endmodule

/* rtl/core/power_status_monitor.sv */
// Power status monitor.
// in_i carries one evaluation word: led_lit, want_on and the free-running
// millisecond timestamp now_ms. out_o returns one status word per input
// word (0 start, 1 on, 2 off, 3 turning on, 4 turning off, 5 turn-on
// error, 6 turn-off error), in order.
// The cfg write port sets the turn-on (index 0) and turn-off (index 1)
// timeouts; write only while no word is in flight. Other indexes ignored.
// Path: an accepted word enters the input register, then the state update
// writes the status into the output register, where out_o.valid rises.
// Throughput: one word per cycle while out_o is taken, set by the state update
// (one 32-bit subtract and compare) between the two registers.
// Reset: status returns to start, stored start time to zero, both
// timeouts to 10000 ms, both pipeline stages empty.
// Stall: when out_o is not taken, the status word holds; the input stage
// still takes one more word, then in_i.ready drops until out_o drains.
module power_status_monitor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [psm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [psm_pkg::TimeW-1:0]   cfg_data_i,
  psm_in_if.sink                      in_i,
  psm_out_if.source                   out_o
);

  // config
  logic [psm_pkg::TimeW-1:0] on_timeout_q, off_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_timeout_q  <= psm_pkg::TurnOnTimeoutRst;
      off_timeout_q <= psm_pkg::TurnOffTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psm_pkg::CfgTurnOnTimeout:  on_timeout_q  <= cfg_data_i;
        psm_pkg::CfgTurnOffTimeout: off_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage
  logic                      in_v_q;
  logic                      led_q, want_q;
  logic [psm_pkg::TimeW-1:0] now_q;
  logic                      out_v_q;
  logic                      advance;

  // input word moves to the output register when that slot is free or draining
  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      led_q  <= in_i.led_lit;
      want_q <= in_i.want_on;
      now_q  <= in_i.now_ms;
    end
  end

  // machine state
  psm_pkg::status_e          state_q;
  logic [psm_pkg::TimeW-1:0] start_ms_q;
  psm_pkg::step_t            step;

  psm_next u_next (
    .state_i      (state_q),
    .led_lit_i    (led_q),
    .want_on_i    (want_q),
    .now_ms_i     (now_q),
    .start_ms_i   (start_ms_q),
    .on_timeout_i (on_timeout_q),
    .off_timeout_i(off_timeout_q),
    .step_o       (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= psm_pkg::StStart;
      start_ms_q <= '0;
    end else if (advance) begin
      state_q <= step.status;
      if (step.load_start) start_ms_q <= now_q;
    end
  end

  // output register: holds the status after the update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.status = state_q;

endmodule

/* rtl/core/psm_checker.sv */
`include "power_status_monitor_macros.svh"

module psm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [psm_pkg::StatusW-1:0] out_status_i
);

  // unused code 7 never shows up
  `PSM_ASSERT_IMPLY(a_status_legal, clk_i, rst_ni, out_valid_i, out_status_i != 3'd7, "status code 7 on output")

  // stalled status word holds
  `PSM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_status_i), "stalled status word changed")

  // backpressure only appears with a full output register
  `PSM_ASSERT_IMPLY(a_ready_low, clk_i, rst_ni, !in_ready_i, out_valid_i, "input stalled with empty output")

  // an accepted word with a free output shows a valid status word after passing the input and output registers
  `PSM_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid_i && in_ready_i && !out_valid_i, ##1 out_valid_i, "status word missing after accept")

endmodule

bind power_status_monitor psm_checker u_psm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_status_i(out_o.status)
);
